### rtl/co2uart_pkg.sv
package co2uart_pkg;

    localparam int unsigned FRAME_LEN = 9;

    typedef logic [3:0] byte_idx_t;

    localparam byte_idx_t IDX_HEAD   = 4'd0;
    localparam byte_idx_t IDX_ADDR   = 4'd1;
    localparam byte_idx_t IDX_CMD    = 4'd2;
    localparam byte_idx_t IDX_ARG0   = 4'd3;
    localparam byte_idx_t IDX_ARG1   = 4'd4;
    localparam byte_idx_t IDX_READ_H = 4'd2;
    localparam byte_idx_t IDX_READ_L = 4'd3;
    localparam byte_idx_t IDX_LAST   = 4'(FRAME_LEN - 1);

    typedef logic [2:0] mode_t;

    localparam mode_t MODE_RX_BYTE  = 3'd0;
    localparam mode_t MODE_READ     = 3'd1;
    localparam mode_t MODE_AUTO_CAL = 3'd2;
    localparam mode_t MODE_FORCE_CAL = 3'd3;
    localparam mode_t MODE_RANGE    = 3'd4;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_TX      = 2'd0;
    localparam kind_t KIND_READING = 2'd1;
    localparam kind_t KIND_REJECT  = 2'd2;
    localparam kind_t KIND_CSUM    = 2'd3;

    localparam logic [7:0] BYTE_HEAD     = 8'hFF;
    localparam logic [7:0] BYTE_ADDR     = 8'h01;
    localparam logic [7:0] CMD_READ      = 8'h86;
    localparam logic [7:0] CMD_AUTO_CAL  = 8'h79;
    localparam logic [7:0] CMD_ZERO_CAL  = 8'h87;
    localparam logic [7:0] CMD_SPAN_CAL  = 8'h88;
    localparam logic [7:0] CMD_RANGE     = 8'h99;
    localparam logic [7:0] ARG_AUTO_ON   = 8'hA0;

    localparam logic [15:0] SPAN_MIN   = 16'd1000;
    localparam logic [15:0] SPAN_MAX   = 16'd5000;
    localparam logic [15:0] RANGE_LOW  = 16'd2000;
    localparam logic [15:0] RANGE_HIGH = 16'd5000;

    // Pending or active result set
    typedef struct packed {
        logic        frame;   // nine transmit bytes, else one result
        kind_t       kind;
        logic [7:0]  cmd;
        logic [7:0]  arg0;
        logic [7:0]  arg1;
        logic [7:0]  csum;
        logic [15:0] reading;
    } result_set_t;

endpackage

### rtl/co2_sensor_uart_frame_engine.sv
// Host-side frame engine for a nine-byte serial CO2 sensor protocol.
// Input channel (in_valid/in_stall) takes one item: a received byte
// (mode 0) or a request (modes 1..4) with its argument in value.
// Output channel (out_valid/out_stall) delivers results: a request gives
// nine transmit bytes (kind 0) or one rejection; the ninth received byte
// of a frame gives a reading or a checksum error. last marks the final
// result of an item. Other received bytes and unused modes give nothing.
// With the output free, the first result of an item passes through the
// pending register and then the active register before it is presented.
// Throughput: one result per cycle while out_stall is low; a request
// occupies the output for nine results, and single-result items sustain
// one per cycle. The rate is set by the one-byte-per-cycle transmit
// sequencer, backed by a one-entry pending register so the next item is
// taken while a frame is still being sent.
// Reset clears the receive byte count and checksum and empties the
// pending and active stages. While out_stall is high the current result
// holds; once the pending entry is full and the active stage cannot
// take it, in_stall rises.
module co2_sensor_uart_frame_engine
    import co2uart_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  mode,
    input  logic [15:0] value,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  tx_byte,
    output logic [15:0] reading,
    output logic        last
);

    logic        in_fire;
    logic        out_fire;
    logic        act_done;
    logic        act_free;

    logic        pend_valid_reg;
    result_set_t pend_reg;
    result_set_t pend_next;
    logic        pend_load;

    logic        act_valid_reg;
    result_set_t act_reg;
    byte_idx_t   act_idx_reg;

    logic [3:0]  rx_count_reg;
    logic [3:0]  rx_count_next;
    logic [7:0]  rx_sum_reg;
    logic [7:0]  rx_sum_next;
    logic [7:0]  reading_high_reg;
    logic [7:0]  reading_low_reg;

    logic [7:0]  sum_body;

    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid && !out_stall;
    assign act_done = out_fire && (!act_reg.frame || act_idx_reg == IDX_LAST);
    assign act_free = !act_valid_reg || act_done;
    assign in_stall = pend_valid_reg && !act_free;

    // Decode the input item into a result set
    always_comb
    begin
        pend_next         = '0;
        pend_load         = 1'b0;
        rx_count_next     = rx_count_reg;
        rx_sum_next       = rx_sum_reg;
        case (mode)
            MODE_RX_BYTE:
            begin
                if (rx_count_reg >= IDX_LAST)
                begin
                    pend_load     = 1'b1;
                    rx_count_next = '0;
                    rx_sum_next   = '0;
                    if (rx_byte == 8'(-rx_sum_reg))
                    begin
                        pend_next.kind    = KIND_READING;
                        pend_next.reading = {reading_high_reg, reading_low_reg};
                    end
                    else
                    begin
                        pend_next.kind = KIND_CSUM;
                    end
                end
                else
                begin
                    rx_count_next = rx_count_reg + 4'd1;
                    if (rx_count_reg != IDX_HEAD)
                    begin
                        rx_sum_next = rx_sum_reg + rx_byte;
                    end
                end
            end
            MODE_READ:
            begin
                pend_load       = 1'b1;
                pend_next.frame = 1'b1;
                pend_next.cmd   = CMD_READ;
            end
            MODE_AUTO_CAL:
            begin
                pend_load       = 1'b1;
                pend_next.frame = 1'b1;
                pend_next.cmd   = CMD_AUTO_CAL;
                pend_next.arg0  = (value != 16'd0) ? ARG_AUTO_ON : 8'h00;
            end
            MODE_FORCE_CAL:
            begin
                pend_load = 1'b1;
                if (value == 16'd0)
                begin
                    pend_next.frame = 1'b1;
                    pend_next.cmd   = CMD_ZERO_CAL;
                end
                else if (value < SPAN_MIN || value > SPAN_MAX)
                begin
                    pend_next.kind = KIND_REJECT;
                end
                else
                begin
                    pend_next.frame = 1'b1;
                    pend_next.cmd   = CMD_SPAN_CAL;
                    pend_next.arg0  = value[15:8];
                    pend_next.arg1  = value[7:0];
                end
            end
            MODE_RANGE:
            begin
                pend_load = 1'b1;
                if (value == RANGE_LOW || value == RANGE_HIGH)
                begin
                    pend_next.frame = 1'b1;
                    pend_next.cmd   = CMD_RANGE;
                    pend_next.arg0  = value[15:8];
                    pend_next.arg1  = value[7:0];
                end
                else
                begin
                    pend_next.kind = KIND_REJECT;
                end
            end
            default:
            begin
                pend_load = 1'b0;
            end
        endcase
        sum_body       = BYTE_ADDR + pend_next.cmd + pend_next.arg0 + pend_next.arg1;
        pend_next.csum = 8'(-sum_body);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_count_reg   <= '0;
            rx_sum_reg     <= '0;
            pend_valid_reg <= 1'b0;
            act_valid_reg  <= 1'b0;
            act_idx_reg    <= IDX_HEAD;
        end
        else
        begin
            if (in_fire)
            begin
                rx_count_reg <= rx_count_next;
                rx_sum_reg   <= rx_sum_next;
            end

            // Pending slot: fill on a producing item, drain into the active stage
            if (in_fire && pend_load)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (act_free)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (act_free)
            begin
                act_valid_reg <= pend_valid_reg;
                act_idx_reg   <= IDX_HEAD;
            end
            else if (out_fire)
            begin
                act_idx_reg <= act_idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && pend_load)
        begin
            pend_reg <= pend_next;
        end
        if (act_free)
        begin
            act_reg <= pend_reg;
        end
        if (in_fire && mode == MODE_RX_BYTE)
        begin
            if (rx_count_reg == IDX_READ_H)
            begin
                reading_high_reg <= rx_byte;
            end
            if (rx_count_reg == IDX_READ_L)
            begin
                reading_low_reg <= rx_byte;
            end
        end
    end

    assign out_valid = act_valid_reg;
    assign kind      = act_reg.frame ? KIND_TX : act_reg.kind;
    assign reading   = act_reg.frame ? 16'd0 : act_reg.reading;
    assign last      = !act_reg.frame || act_idx_reg == IDX_LAST;

    always_comb
    begin
        tx_byte = 8'h00;
        if (act_reg.frame)
        begin
            case (act_idx_reg)
                IDX_HEAD: tx_byte = BYTE_HEAD;
                IDX_ADDR: tx_byte = BYTE_ADDR;
                IDX_CMD:  tx_byte = act_reg.cmd;
                IDX_ARG0: tx_byte = act_reg.arg0;
                IDX_ARG1: tx_byte = act_reg.arg1;
                IDX_LAST: tx_byte = act_reg.csum;
                default:  tx_byte = 8'h00;
            endcase
        end
    end

endmodule
